// ----- rtl/multi_button_press_classifier_defines.svh -----
// Assertion macros shared by the button press classifier RTL.
// Clock clk and active-high reset rst are assumed in the including module.
`ifndef MULTI_BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define MULTI_BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define BPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define BPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BPC_ASSERT_NOW(label, ante, cons)
`define BPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/bpc_pkg.sv -----
// Types and constants for the button press classifier.
// No dependencies; used by every module of the block.
package bpc_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int MAX_RESULTS     = 4;
  localparam int PIN_BITS        = 4;
  localparam int MS_W            = 32;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int RES_CNT_W       = 3;
  localparam int BTN_W           = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CFG_W-1:0] LONG_RESET     = 16'd2000;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 1'd1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_EDGE = 2'd1,
    OP_POLL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_HELD    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BOUNCE = 2'd0,
    KIND_SHORT  = 2'd1,
    KIND_LONG   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

  typedef struct packed {
    logic             push;
    logic             flush;
    logic [BTN_W-1:0] button;
    kind_t            kind;
  } emit_cmd_t;

endpackage

// ----- rtl/bpc_cmp_unit.sv -----
// Shared elapsed-time unit: one wrapping subtract and two threshold compares.
// Depends on bpc_pkg.
module bpc_cmp_unit (
  input  logic [bpc_pkg::MS_W-1:0]  ms_now,
  input  logic [bpc_pkg::MS_W-1:0]  press_time,
  input  logic [bpc_pkg::CFG_W-1:0] debounce_ms,
  input  logic [bpc_pkg::CFG_W-1:0] long_press_ms,
  output logic                      ge_debounce,
  output bpc_pkg::kind_t            kind
);

  logic [bpc_pkg::MS_W-1:0] elapsed;
  logic                     upper_set;
  logic                     ge_long;

  assign elapsed     = ms_now - press_time;
  assign upper_set   = |elapsed[bpc_pkg::MS_W-1:bpc_pkg::CFG_W];
  assign ge_debounce = upper_set || (elapsed[bpc_pkg::CFG_W-1:0] >= debounce_ms);
  assign ge_long     = upper_set || (elapsed[bpc_pkg::CFG_W-1:0] >= long_press_ms);

  always_comb begin
    if (ge_long) begin
      kind = bpc_pkg::KIND_LONG;
    end else if (ge_debounce) begin
      kind = bpc_pkg::KIND_SHORT;
    end else begin
      kind = bpc_pkg::KIND_BOUNCE;
    end
  end

endmodule

// ----- rtl/bpc_out_stage.sv -----
// Result stage: one pending slot plus the output register, so tlast can be set
// on the final result of a poll. Depends on bpc_pkg and the assertion header.
`include "multi_button_press_classifier_defines.svh"

module bpc_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  bpc_pkg::emit_cmd_t cmd,
  output logic               ready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,  // [1:0] released_button, [7:2] zero
  output logic [1:0]         m_tuser,  // [1:0] press_kind
  output logic               m_tlast   // last
);

  logic                      pend_valid;
  logic [bpc_pkg::BTN_W-1:0] pend_button;
  bpc_pkg::kind_t            pend_kind;
  logic [bpc_pkg::BTN_W-1:0] out_button;
  bpc_pkg::kind_t            out_kind;
  logic                      out_free;
  logic                      load;

  assign out_free = !m_tvalid || m_tready;
  assign ready    = !pend_valid || out_free;
  assign load     = pend_valid && out_free && (cmd.push || cmd.flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.push && ready) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush && ready) begin
        pend_valid <= 1'b0;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && ready) begin
      pend_button <= cmd.button;
      pend_kind   <= cmd.kind;
    end
    if (load) begin
      out_button <= pend_button;
      out_kind   <= pend_kind;
      m_tlast    <= cmd.flush;
    end
  end

  assign m_tdata = {6'b000000, out_button};
  assign m_tuser = out_kind;

  // flush empties the pending slot once the output side has room
  `BPC_ASSERT_NEXT(a_flush_drains, cmd.flush && ready, !pend_valid)
  // a pushed result always lands in the pending slot
  `BPC_ASSERT_NEXT(a_push_lands, cmd.push && ready, pend_valid)
  // a load always shows a valid result on the next cycle
  `BPC_ASSERT_NEXT(a_load_shows, load, m_tvalid)

endmodule

// ----- rtl/multi_button_press_classifier.sv -----
// Button press classifier top level: config registers, ms counter, sequencer.
// Depends on bpc_pkg, bpc_cmp_unit, bpc_out_stage and the assertion header.
//
//  Channel  Dir  tdata (low bit first)            tuser            Handshake
//  s_*      in   button[1:0] pin_levels[5:2]      operation[1:0]   tvalid/tready
//  m_*      out  released_button[1:0], tlast      press_kind[1:0]  tvalid/tready
//  cfg_*    in   cfg_index, cfg_data[15:0]        -                cfg_we
//
// A tick or an edge item is applied as it is accepted. A poll item is accepted,
// then each button goes in turn through the shared elapsed-time unit, and a
// last step marks the final result; no new item is accepted until the poll is done.
// A scan step that emits a result, and the final marking step, wait while the
// output side is stalled and the pending slot is full. rst is synchronous; it
// clears the counter, all button phases and the config to default values.
`include "multi_button_press_classifier_defines.svh"

module multi_button_press_classifier #(
  parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // [1:0] button, [5:2] pin_levels, [7:6] 0
  input  logic [1:0]                    s_tuser,  // [1:0] operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,  // [1:0] released_button, [7:2] 0
  output logic [1:0]                    m_tuser,  // [1:0] press_kind
  output logic                          m_tlast,  // last
  input  logic                          cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  bpc_pkg::state_t state, state_next;

  logic [bpc_pkg::CFG_W-1:0]     debounce_ms;
  logic [bpc_pkg::CFG_W-1:0]     long_press_ms;
  logic [bpc_pkg::MS_W-1:0]      ms_counter;
  bpc_pkg::phase_t               button_phase [NUM_BUTTONS];
  logic [bpc_pkg::MS_W-1:0]      press_time   [NUM_BUTTONS];
  logic [bpc_pkg::PIN_BITS-1:0]  pin_reg;
  logic [IdxW-1:0]               scan_idx;
  logic [bpc_pkg::RES_CNT_W-1:0] res_count;

  logic [1:0]                   in_op;
  logic [bpc_pkg::BTN_W-1:0]    in_button;
  logic [bpc_pkg::PIN_BITS-1:0] in_pins;
  logic                         in_accept;
  logic [IdxW-1:0]              edge_idx;
  logic                         edge_ok;

  logic [4:0]                   idx_wide;
  bpc_pkg::phase_t              cur_phase;
  logic                         cur_high;
  logic                         scan_last;
  logic                         ge_debounce;
  bpc_pkg::kind_t               cur_kind;
  logic                         emit;
  logic                         step_ok;
  logic                         stage_ready;
  bpc_pkg::emit_cmd_t           cmd;

  assign in_op     = s_tuser;
  assign in_button = s_tdata[1:0];
  assign in_pins   = s_tdata[5:2];
  assign in_accept = s_tvalid && s_tready;
  assign edge_idx  = IdxW'(in_button);
  assign edge_ok   = (int'(in_button) < NUM_BUTTONS) && (button_phase[edge_idx] == bpc_pkg::PH_IDLE);

  assign idx_wide  = 5'(scan_idx);
  assign cur_phase = button_phase[scan_idx];
  // buttons beyond the pin field read as pressed
  assign cur_high  = (idx_wide < 5'(bpc_pkg::PIN_BITS)) && pin_reg[idx_wide[1:0]];
  assign scan_last = (scan_idx == IdxW'(NUM_BUTTONS - 1));

  bpc_cmp_unit u_cmp (
    .ms_now        (ms_counter),
    .press_time    (press_time[scan_idx]),
    .debounce_ms   (debounce_ms),
    .long_press_ms (long_press_ms),
    .ge_debounce   (ge_debounce),
    .kind          (cur_kind)
  );

  bpc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .ready    (stage_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bpc_pkg::ST_IDLE: begin
        if (in_accept && (in_op == bpc_pkg::OP_POLL)) begin
          state_next = bpc_pkg::ST_SCAN;
        end
      end
      bpc_pkg::ST_SCAN: begin
        if (step_ok && scan_last) begin
          state_next = bpc_pkg::ST_FLUSH;
        end
      end
      bpc_pkg::ST_FLUSH: begin
        if (stage_ready) begin
          state_next = bpc_pkg::ST_IDLE;
        end
      end
      default: state_next = bpc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready   = 1'b0;
    emit       = 1'b0;
    step_ok    = 1'b0;
    cmd        = '0;
    cmd.button = bpc_pkg::BTN_W'(idx_wide);
    cmd.kind   = cur_kind;
    case (state)
      bpc_pkg::ST_IDLE: s_tready = 1'b1;
      bpc_pkg::ST_SCAN: begin
        emit     = (cur_phase == bpc_pkg::PH_HELD) && cur_high &&
                   (res_count < bpc_pkg::RES_CNT_W'(bpc_pkg::MAX_RESULTS));
        step_ok  = !emit || stage_ready;
        cmd.push = emit && stage_ready;
      end
      bpc_pkg::ST_FLUSH: cmd.flush = 1'b1;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bpc_pkg::ST_IDLE;
      debounce_ms   <= bpc_pkg::DEBOUNCE_RESET;
      long_press_ms <= bpc_pkg::LONG_RESET;
      ms_counter    <= '0;
      scan_idx      <= '0;
      res_count     <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        button_phase[i] <= bpc_pkg::PH_IDLE;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          bpc_pkg::CFG_DEBOUNCE: debounce_ms   <= cfg_data;
          bpc_pkg::CFG_LONG:     long_press_ms <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        case (in_op)
          bpc_pkg::OP_TICK: ms_counter <= ms_counter + bpc_pkg::MS_W'(1);
          bpc_pkg::OP_EDGE: begin
            if (edge_ok) begin
              button_phase[edge_idx] <= bpc_pkg::PH_PRESSED;
            end
          end
          bpc_pkg::OP_POLL: begin
            scan_idx  <= '0;
            res_count <= '0;
          end
          default: ;
        endcase
      end
      if ((state == bpc_pkg::ST_SCAN) && step_ok) begin
        scan_idx <= scan_idx + IdxW'(1);
        case (cur_phase)
          bpc_pkg::PH_IDLE: ;
          bpc_pkg::PH_PRESSED: begin
            if (ge_debounce) begin
              button_phase[scan_idx] <= cur_high ? bpc_pkg::PH_IDLE : bpc_pkg::PH_HELD;
            end
          end
          bpc_pkg::PH_HELD: begin
            if (emit) begin
              button_phase[scan_idx] <= bpc_pkg::PH_IDLE;
              res_count              <= res_count + bpc_pkg::RES_CNT_W'(1);
            end
          end
          default: button_phase[scan_idx] <= bpc_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // record press time and sample pins
  always_ff @(posedge clk) begin
    if (in_accept && (in_op == bpc_pkg::OP_EDGE) && edge_ok) begin
      press_time[edge_idx] <= ms_counter;
    end
    if (in_accept && (in_op == bpc_pkg::OP_POLL)) begin
      pin_reg <= in_pins;
    end
  end

  `BPC_ASSERT_NEXT(a_poll_starts_scan, in_accept && (in_op == bpc_pkg::OP_POLL),
                   (state == bpc_pkg::ST_SCAN) && (scan_idx == '0) && (res_count == '0))
  `BPC_ASSERT_NEXT(a_ms_holds, !(in_accept && (in_op == bpc_pkg::OP_TICK)), $stable(ms_counter))
  `BPC_ASSERT_NOW(a_res_limit, 1'b1,
                  res_count <= bpc_pkg::RES_CNT_W'(bpc_pkg::MAX_RESULTS))
  `BPC_ASSERT_NEXT(a_scan_ends, (state == bpc_pkg::ST_SCAN) && step_ok && scan_last,
                   state == bpc_pkg::ST_FLUSH)

endmodule

// ----- tb/multi_button_press_classifier_tb.sv -----
// Self-checking testbench for the multi-button short/long press classifier.
// Depends on bpc_pkg and multi_button_press_classifier; predicts every release
// classification and checks the output stream against it.
module multi_button_press_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB            = bpc_pkg::NUM_BUTTONS_DEF;
  localparam int SETTLE_CYCLES = NB + 12;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [bpc_pkg::BTN_W-1:0] button;
    bpc_pkg::kind_t            kind;
    logic                      last;
  } release_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'd0;  // [1:0] button, [5:2] pin_levels, [7:6] 0
  logic [1:0]       s_tuser = 2'd0;  // [1:0] operation
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;         // [1:0] released_button, [7:2] 0
  logic [1:0]       m_tuser;         // [1:0] press_kind
  logic             m_tlast;         // last
  logic             cfg_we = 1'b0;
  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bpc_pkg::CFG_W-1:0]     cfg_data = '0;

  // Predicted block state
  logic [bpc_pkg::MS_W-1:0]  ms_model;
  bpc_pkg::phase_t           phase_model [NB];
  logic [bpc_pkg::MS_W-1:0]  press_stamp [NB];
  logic [bpc_pkg::CFG_W-1:0] debounce_model;
  logic [bpc_pkg::CFG_W-1:0] long_model;

  release_t pending_releases[$];

  int  error_count = 0;
  int  events_sent = 0;
  int  releases_seen = 0;
  int  kind_tally [3] = '{0, 0, 0};
  int  cycle_count = 0;
  bit  tx_gaps_on = 1'b0;
  bit  rx_stalls_on = 1'b0;
  int  hold_cycles = 0;
  int  stall_left = 0;

  multi_button_press_classifier #(.NUM_BUTTONS(NB)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d releases outstanding",
               cycle_count, pending_releases.size());
      $display("multi_button_press_classifier_tb failed");
      $finish;
    end
  end

  // Output side: random stalls, plus a long hold-off when a test requests one.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (rx_stalls_on && $urandom_range(0, 7) == 0)
        stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 4);
    end
  end

  always @(posedge clk) begin : release_check
    release_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_releases.size() == 0) begin
        $error("unexpected result: released_button %0d press_kind %0d last %0b",
               m_tdata[1:0], m_tuser, m_tlast);
        error_count++;
      end else begin
        want = pending_releases.pop_front();
        releases_seen++;
        if (want.kind <= bpc_pkg::KIND_LONG)
          kind_tally[want.kind]++;
        if (m_tdata[1:0] != want.button) begin
          $error("released_button: expected %0d, got %0d", want.button, m_tdata[1:0]);
          error_count++;
        end
        if (m_tuser != want.kind) begin
          $error("press_kind: expected %0d, got %0d", want.kind, m_tuser);
          error_count++;
        end
        if (m_tlast != want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          error_count++;
        end
        if (m_tdata[7:2] != 6'd0) begin
          $error("padding: expected 0, got %0h", m_tdata[7:2]);
          error_count++;
        end
      end
    end
  end

  task automatic reset_model();
    int i;
    ms_model = '0;
    for (i = 0; i < NB; i++) begin
      phase_model[i] = bpc_pkg::PH_IDLE;
      press_stamp[i] = '0;
    end
    debounce_model = bpc_pkg::DEBOUNCE_RESET;
    long_model     = bpc_pkg::LONG_RESET;
  endtask

  // Advance the model by one accepted item and queue the releases it classifies.
  // The item is packed as {pin_levels, button, operation}.
  task automatic predict_releases(input logic [7:0] data);
    bpc_pkg::op_t             op;
    logic [1:0]               btn;
    logic [3:0]               pins;
    logic                     high;
    logic [bpc_pkg::MS_W-1:0] elapsed;
    release_t                 rel;
    release_t                 found[$];
    int                       i;
    op   = bpc_pkg::op_t'(data[1:0]);
    btn  = data[3:2];
    pins = data[7:4];
    case (op)
      bpc_pkg::OP_TICK: ms_model = ms_model + 1;
      bpc_pkg::OP_EDGE: begin
        if ((int'(btn) < NB) && (phase_model[btn] == bpc_pkg::PH_IDLE)) begin
          press_stamp[btn] = ms_model;
          phase_model[btn] = bpc_pkg::PH_PRESSED;
        end
      end
      bpc_pkg::OP_POLL: begin
        for (i = 0; i < NB; i++) begin
          elapsed = ms_model - press_stamp[i];
          // buttons beyond the pin field read as pressed
          high = (i < bpc_pkg::PIN_BITS) ? pins[i] : 1'b0;
          case (phase_model[i])
            bpc_pkg::PH_IDLE: ;
            bpc_pkg::PH_PRESSED: begin
              if (elapsed >= bpc_pkg::MS_W'(debounce_model))
                phase_model[i] = high ? bpc_pkg::PH_IDLE : bpc_pkg::PH_HELD;
            end
            bpc_pkg::PH_HELD: begin
              if (high && found.size() < bpc_pkg::MAX_RESULTS) begin
                rel.button = bpc_pkg::BTN_W'(i);
                if (elapsed >= bpc_pkg::MS_W'(long_model))
                  rel.kind = bpc_pkg::KIND_LONG;
                else if (elapsed >= bpc_pkg::MS_W'(debounce_model))
                  rel.kind = bpc_pkg::KIND_SHORT;
                else
                  rel.kind = bpc_pkg::KIND_BOUNCE;
                rel.last = 1'b0;
                found.push_back(rel);
                phase_model[i] = bpc_pkg::PH_IDLE;
              end
            end
            default: phase_model[i] = bpc_pkg::PH_IDLE;
          endcase
        end
        if (found.size() > 0) begin
          rel = found.pop_back();
          rel.last = 1'b1;
          found.push_back(rel);
        end
        foreach (found[k])
          pending_releases.push_back(found[k]);
      end
      default: ;  // unused code: ignored
    endcase
  endtask

  function automatic logic [7:0] make_event(bpc_pkg::op_t op, logic [1:0] btn,
                                            logic [3:0] pins);
    return {pins, btn, op};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_event(input logic [7:0] data);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= data[1:0];
    s_tdata  <= {2'b00, data[7:2]};
    do @(posedge clk); while (!s_tready);
    predict_releases(data);
    events_sent++;
  endtask

  // Drop valid, wait for every predicted release, then let a silent poll finish.
  task automatic drain_and_settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_releases.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpc_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bpc_pkg::CFG_DEBOUNCE)
      debounce_model = value;
    else
      long_model = value;
  endtask

  task automatic test_directed_sequence();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    write_reg(bpc_pkg::CFG_DEBOUNCE, 16'd2);
    write_reg(bpc_pkg::CFG_LONG, 16'd5);
    send_event(make_event(bpc_pkg::OP_EDGE, 2'd0, 4'h0));
    send_event(make_event(bpc_pkg::OP_EDGE, 2'd1, 4'h0));
    send_event(make_event(bpc_pkg::OP_EDGE, 2'd0, 4'h0));   // not idle: ignored
    send_event(8'hFF);                                       // unused operation code
    send_event(make_event(bpc_pkg::OP_POLL, 2'd0, 4'h0));   // still inside debounce
    send_event(make_event(bpc_pkg::OP_TICK, 2'd0, 4'h0));
    send_event(make_event(bpc_pkg::OP_TICK, 2'd0, 4'h0));
    send_event(make_event(bpc_pkg::OP_POLL, 2'd0, 4'b0010)); // 0 held, 1 back to idle
    send_event(make_event(bpc_pkg::OP_EDGE, 2'd2, 4'h0));
    send_event(make_event(bpc_pkg::OP_EDGE, 2'd3, 4'h0));
    repeat (3) send_event(make_event(bpc_pkg::OP_TICK, 2'd0, 4'hF));
    send_event(make_event(bpc_pkg::OP_POLL, 2'd1, 4'h0));
    send_event(make_event(bpc_pkg::OP_POLL, 2'd3, 4'hF));   // long on 0, short on 2 and 3
  endtask

  task automatic test_extreme_settings();
    int b;
    drain_and_settle();
    write_reg(bpc_pkg::CFG_DEBOUNCE, 16'd0);
    write_reg(bpc_pkg::CFG_LONG, 16'hFFFF);
    for (b = 0; b < NB; b++)
      send_event(make_event(bpc_pkg::OP_EDGE, 2'(b), 4'h0));
    send_event(make_event(bpc_pkg::OP_POLL, 2'd0, 4'h0));
    // Raise debounce under held buttons so their release counts as bounce.
    drain_and_settle();
    write_reg(bpc_pkg::CFG_DEBOUNCE, 16'hFFFF);
    send_event(make_event(bpc_pkg::OP_POLL, 2'd0, 4'hF));
    drain_and_settle();
    write_reg(bpc_pkg::CFG_DEBOUNCE, 16'd0);
    write_reg(bpc_pkg::CFG_LONG, 16'd0);
    for (b = 0; b < NB; b++)
      send_event(make_event(bpc_pkg::OP_EDGE, 2'(b), 4'h0));
    send_event(make_event(bpc_pkg::OP_POLL, 2'd0, 4'h0));
    send_event(make_event(bpc_pkg::OP_POLL, 2'd0, 4'hF));
  endtask

  task automatic test_output_backpressure();
    int round;
    int b;
    drain_and_settle();
    write_reg(bpc_pkg::CFG_DEBOUNCE, 16'd0);
    write_reg(bpc_pkg::CFG_LONG, 16'd3);
    tx_gaps_on = 1'b0;
    @(posedge clk);
    hold_cycles = 300;
    for (round = 0; round < 8; round++) begin
      for (b = 0; b < NB; b++)
        send_event(make_event(bpc_pkg::OP_EDGE, 2'(b), 4'h0));
      send_event(make_event(bpc_pkg::OP_POLL, 2'd0, 4'h0));
      repeat ($urandom_range(0, 5)) send_event(make_event(bpc_pkg::OP_TICK, 2'd0, 4'h0));
      send_event(make_event(bpc_pkg::OP_POLL, 2'd0, 4'hF));
    end
  endtask

  task automatic test_random_traffic();
    int       round;
    int       n;
    int       r;
    int       b;
    logic [15:0] deb;
    logic [3:0]  pins;
    for (round = 0; round < 4; round++) begin
      drain_and_settle();
      deb = 16'($urandom_range(0, 6));
      write_reg(bpc_pkg::CFG_DEBOUNCE, deb);
      write_reg(bpc_pkg::CFG_LONG, deb + 16'($urandom_range(0, 25)));
      tx_gaps_on   = (round != 1);
      rx_stalls_on = (round != 2);
      n = 0;
      while (n < 75) begin
        r = $urandom_range(0, 99);
        for (b = 0; b < 4; b++)
          pins[b] = ($urandom_range(0, 99) < 35);
        if (r < 4) begin
          send_event({4'($urandom), 2'($urandom), 2'd3});  // noise
        end else begin
          if (r < 48)
            send_event(make_event(bpc_pkg::OP_TICK, 2'($urandom), 4'($urandom)));
          else if (r < 70)
            send_event(make_event(bpc_pkg::OP_EDGE, 2'($urandom), 4'($urandom)));
          else
            send_event(make_event(bpc_pkg::OP_POLL, 2'($urandom), pins));
          n++;
        end
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed_sequence();
    test_extreme_settings();
    test_output_backpressure();
    test_random_traffic();
    drain_and_settle();
    if (pending_releases.size() != 0) begin
      $error("%0d predicted releases never arrived", pending_releases.size());
      error_count++;
    end
    $display("sent %0d button events under several debounce/long-press settings",
             events_sent);
    $display("checked %0d releases: %0d bounce, %0d short, %0d long; %0d mismatches",
             releases_seen, kind_tally[0], kind_tally[1], kind_tally[2], error_count);
    if (error_count == 0)
      $display("multi_button_press_classifier_tb passed");
    else
      $display("multi_button_press_classifier_tb failed");
    $finish;
  end

endmodule
